// File: design/lhtl_pkg.sv
// lhtl_pkg: shared types and constants of the lower hull tie-line finder
`timescale 1ns / 1ps

package lhtl_pkg;

  // field widths
  localparam int unsigned XW = 17;
  localparam int unsigned EW = 32;
  localparam int unsigned PW = 4;

  // reset value of the gap threshold
  localparam logic [XW-1:0] GapReset = XW'(993);

  // one hull stack entry
  typedef struct packed {
    logic [XW-1:0]        x;
    logic signed [EW-1:0] e;
    logic [PW-1:0]        phase;
  } entry_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load_point;  // capture the incoming point
    logic push;        // push the held point, or flag overflow when full
    logic pop;         // drop the top vertex
    logic refill_rd;   // address the stack at the new second entry
    logic refill;      // load the second entry from the stack read data
    logic emit_first;  // take vertex 0 as the current vertex
    logic emit_step;   // present the current vertex, advance to the next
    logic emit_last;   // present the final vertex and clear the hull
    logic rd_inc;      // advance the emission read index
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic dup;       // point has the composition of the top vertex
    logic cnt_ge2;   // two or more vertices held
    logic cnt_ge3;   // three or more vertices held
    logic pop_ok;    // turn is not strictly positive
    logic last_pt;   // held point closes the set
    logic single;    // hull has one vertex
    logic more;      // another vertex follows the one being read
    logic out_free;  // output register can take a result
    logic rd_zero;   // emission read index is at the first vertex
  } status_t;

endpackage

// File: design/lhtl_ram.sv
// lhtl_ram: generic single write port, single read port RAM with registered read
`timescale 1ns / 1ps

module lhtl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/lhtl_ctrl.sv
// lhtl_ctrl: sequencer for point insertion and hull emission
`timescale 1ns / 1ps

module lhtl_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_tvalid_i,
  output logic             s_tready_o,
  input  lhtl_pkg::status_t status_i,
  output lhtl_pkg::cmd_t    cmd_o
);

  typedef enum logic [9:0] {
    StIdle   = 10'b00_0000_0001,
    StDup    = 10'b00_0000_0010,
    StCmp    = 10'b00_0000_0100,
    StRefill = 10'b00_0000_1000,
    StMul    = 10'b00_0001_0000,
    StPush   = 10'b00_0010_0000,
    StEWait  = 10'b00_0100_0000,
    StEFirst = 10'b00_1000_0000,
    StEStep  = 10'b01_0000_0000,
    StELast  = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;
  state_e done_st;

  // where to go once the point has been pushed or skipped
  assign done_st = status_i.last_pt ? StEWait : StIdle;

  assign s_tready_o = (state_q == StIdle);

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (s_tvalid_i) begin
          cmd_o.load_point = 1'b1;
          state_d          = StDup;
        end
      end
      StDup: begin
        if (status_i.dup) begin
          state_d = done_st;
        end else if (status_i.cnt_ge2) begin
          state_d = StCmp;
        end else begin
          cmd_o.push = 1'b1;
          state_d    = done_st;
        end
      end
      StCmp: begin
        cmd_o.refill_rd = 1'b1;
        if (status_i.pop_ok) begin
          cmd_o.pop = 1'b1;
          state_d   = status_i.cnt_ge3 ? StRefill : StPush;
        end else begin
          cmd_o.push = 1'b1;
          state_d    = done_st;
        end
      end
      StRefill: begin
        cmd_o.refill = 1'b1;
        state_d      = StMul;
      end
      StMul: begin
        state_d = StCmp;
      end
      StPush: begin
        cmd_o.push = 1'b1;
        state_d    = done_st;
      end
      StEWait: begin
        state_d = status_i.rd_zero ? StEFirst : StEStep;
      end
      StEFirst: begin
        cmd_o.emit_first = 1'b1;
        if (status_i.single) begin
          state_d = StELast;
        end else begin
          cmd_o.rd_inc = 1'b1;
          state_d      = StEWait;
        end
      end
      StEStep: begin
        if (status_i.out_free) begin
          cmd_o.emit_step = 1'b1;
          if (status_i.more) begin
            cmd_o.rd_inc = 1'b1;
            state_d      = StEWait;
          end else begin
            state_d = StELast;
          end
        end
      end
      StELast: begin
        if (status_i.out_free) begin
          cmd_o.emit_last = 1'b1;
          state_d         = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: design/lhtl_datapath.sv
// lhtl_datapath: hull stack, turn evaluation and vertex output register
`timescale 1ns / 1ps

module lhtl_datapath #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lhtl_pkg::XW-1:0]       cfg_wdata_i,
  input  lhtl_pkg::entry_t              point_i,
  input  logic                          point_last_i,
  input  lhtl_pkg::cmd_t                cmd_i,
  output lhtl_pkg::status_t             status_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [lhtl_pkg::XW-1:0]       out_x_o,
  output logic [lhtl_pkg::PW-1:0]       out_phase_o,
  output logic                          out_tie_o,
  output logic                          out_ovf_o,
  output logic                          out_last_o
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned XW = lhtl_pkg::XW;
  localparam int unsigned EW = lhtl_pkg::EW;
  localparam int unsigned PRW = XW + EW + 2;

  // control state
  logic [XW-1:0] gap_q, gap_d;
  logic [CW-1:0] count_q, count_d;
  logic          ovf_q, ovf_d;
  logic [AW-1:0] rd_idx_q, rd_idx_d;
  logic          out_valid_q, out_valid_d;

  // payload state
  lhtl_pkg::entry_t p_q, top_q, sec_q, cur_q;
  logic             p_last_q;
  logic signed [PRW-1:0] prod1_q, prod2_q;
  logic [XW-1:0]         out_x_q;
  logic [lhtl_pkg::PW-1:0] out_phase_q;
  logic                  out_tie_q, out_ovf_q, out_last_q;

  logic             full;
  logic             do_write;
  logic [AW-1:0]    raddr;
  logic [CW-1:0]    refill_addr;
  logic [CW-1:0]    rd_next;
  lhtl_pkg::entry_t rdata;

  logic signed [XW:0]    dx1, dx2;
  logic signed [EW:0]    de1, de2;
  logic signed [PRW-1:0] prod1_d, prod2_d;
  logic signed [PRW:0]   turn;
  logic signed [XW:0]    gap_diff;
  logic                  tie_step;

  assign full     = (count_q == CW'(STACK_DEPTH));
  assign do_write = cmd_i.push && !full;

  // stack read address: refill reads the entry below the new top
  assign refill_addr = count_q - CW'(3);
  assign raddr       = cmd_i.refill_rd ? refill_addr[AW-1:0] : rd_idx_q;

  lhtl_ram #(
    .WIDTH ($bits(lhtl_pkg::entry_t)),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (do_write),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (p_q),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // turn of (second, top, point): two products, registered
  always_comb begin
    dx1     = $signed({1'b0, top_q.x}) - $signed({1'b0, sec_q.x});
    dx2     = $signed({1'b0, p_q.x}) - $signed({1'b0, sec_q.x});
    de1     = $signed({top_q.e[EW-1], top_q.e}) - $signed({sec_q.e[EW-1], sec_q.e});
    de2     = $signed({p_q.e[EW-1], p_q.e}) - $signed({sec_q.e[EW-1], sec_q.e});
    prod1_d = PRW'(dx1 * de2);
    prod2_d = PRW'(de1 * dx2);
  end

  assign turn = $signed({prod1_q[PRW-1], prod1_q}) - $signed({prod2_q[PRW-1], prod2_q});

  // tie-line test between the current vertex and the one just read
  assign gap_diff = $signed({1'b0, rdata.x}) - $signed({1'b0, cur_q.x});
  assign tie_step = (gap_diff > $signed({1'b0, gap_q})) || (rdata.phase != cur_q.phase);

  assign rd_next = CW'(rd_idx_q) + CW'(1);

  // status towards the controller
  always_comb begin
    status_o          = '0;
    status_o.dup      = (count_q != '0) && (top_q.x == p_q.x);
    status_o.cnt_ge2  = (count_q >= CW'(2));
    status_o.cnt_ge3  = (count_q >= CW'(3));
    status_o.pop_ok   = turn[PRW] || (turn == '0);
    status_o.last_pt  = p_last_q;
    status_o.single   = (count_q == CW'(1));
    status_o.more     = (rd_next < count_q);
    status_o.out_free = !out_valid_q || out_ready_i;
    status_o.rd_zero  = (rd_idx_q == '0);
  end

  // next values of control state
  always_comb begin
    gap_d       = gap_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    rd_idx_d    = rd_idx_q;
    out_valid_d = out_valid_q;
    if (cfg_we_i) begin
      gap_d = cfg_wdata_i;
    end
    if (cmd_i.load_point) begin
      rd_idx_d = '0;
    end else if (cmd_i.rd_inc) begin
      rd_idx_d = rd_idx_q + AW'(1);
    end
    if (do_write) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.push) begin
      ovf_d = 1'b1;
    end else if (cmd_i.pop) begin
      count_d = count_q - CW'(1);
    end else if (cmd_i.emit_last) begin
      count_d = '0;
      ovf_d   = 1'b0;
    end
    if (cmd_i.emit_step || cmd_i.emit_last) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q       <= lhtl_pkg::GapReset;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      gap_q       <= gap_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      rd_idx_q    <= rd_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    prod1_q <= prod1_d;
    prod2_q <= prod2_d;
    if (cmd_i.load_point) begin
      p_q      <= point_i;
      p_last_q <= point_last_i;
    end
    if (do_write) begin
      sec_q <= top_q;
      top_q <= p_q;
    end else if (cmd_i.pop) begin
      top_q <= sec_q;
    end else if (cmd_i.refill) begin
      sec_q <= rdata;
    end
    if (cmd_i.emit_first || cmd_i.emit_step) begin
      cur_q <= rdata;
    end
    if (cmd_i.emit_step || cmd_i.emit_last) begin
      out_x_q     <= cur_q.x;
      out_phase_q <= cur_q.phase;
      out_tie_q   <= cmd_i.emit_step ? tie_step : 1'b0;
      out_ovf_q   <= ovf_q;
      out_last_q  <= cmd_i.emit_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_x_o     = out_x_q;
  assign out_phase_o = out_phase_q;
  assign out_tie_o   = out_tie_q;
  assign out_ovf_o   = out_ovf_q;
  assign out_last_o  = out_last_q;

  // stack never holds more than its depth
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(STACK_DEPTH))
    else $error("hull stack count beyond depth");

  // a pop always leaves at least one vertex
  a_pop_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> count_q >= CW'(2))
    else $error("pop with fewer than two vertices");

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit_step || cmd_i.emit_last) |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten");

  // a push into a full stack raises the overflow flag
  a_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.push && full) |=> ovf_q)
    else $error("overflow not flagged");

endmodule

// File: design/lower_hull_tie_line_finder_top.sv
// lower_hull_tie_line_finder_top: top level of the lower hull tie-line finder
`timescale 1ns / 1ps

// Points arrive sorted by composition and then energy; each is held on a
// monotone chain stack that keeps the lower convex hull. A point is taken only
// in the idle state, so each point is finished before the next is taken. A point
// that repeats the composition of the top vertex is skipped; otherwise, with
// two or more vertices held, it is turn-tested against the top two, and with
// fewer held it is pushed directly. Every vertex popped while two or more stay
// brings a refill and a new turn test: the turn is formed in two stages
// (registered products, then the subtract and sign test) and the vertex below
// the new top comes back from the one read port of the stack memory. A pop
// that leaves a single vertex is followed directly by the push of the point.
// On the point marked last the hull is sent out one vertex at a time, each
// stack read needing its own registered access; a stalled output holds the
// sequence. The next set may be transferred in while the final vertex still
// waits. The stack holds STACK_DEPTH vertices; a point that finds it full is
// dropped and every vertex of that set carries the overflow flag.
module lower_hull_tie_line_finder_top #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: gap threshold
  input  logic        cfg_we_i,
  input  logic [16:0] cfg_wdata_i,
  // point input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // comp_x[16:0], energy[48:17], phase_id[52:49], zero
  input  logic        s_axis_tlast,  // last_point
  // hull vertex output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // vertex_x[16:0], vertex_phase[20:17], zero
  output logic [1:0]  m_axis_tuser,  // two_phase_next[0], stack_overflow[1]
  output logic        m_axis_tlast   // last_vertex
);

  lhtl_pkg::cmd_t    cmd;
  lhtl_pkg::status_t status;
  lhtl_pkg::entry_t  point;

  logic [lhtl_pkg::XW-1:0] out_x;
  logic [lhtl_pkg::PW-1:0] out_phase;
  logic                    out_tie, out_ovf;

  // unpack the point transfer
  assign point.x     = s_axis_tdata[16:0];
  assign point.e     = s_axis_tdata[48:17];
  assign point.phase = s_axis_tdata[52:49];

  lhtl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lhtl_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .point_i      (point),
    .point_last_i (s_axis_tlast),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_x_o      (out_x),
    .out_phase_o  (out_phase),
    .out_tie_o    (out_tie),
    .out_ovf_o    (out_ovf),
    .out_last_o   (m_axis_tlast)
  );

  // pack the vertex transfer
  assign m_axis_tdata = {3'b000, out_phase, out_x};
  assign m_axis_tuser = {out_ovf, out_tie};

endmodule
